// ===== hdl/rscc_pkg.sv =====
// types, codes and command/status structs for the rectangle clearance checker
// used by the datapath, controller, top level and bench; depends on nothing
`timescale 1ns / 1ps

package rscc_pkg;

	localparam int unsigned DW = 32;

	// register indexes of the configuration port
	localparam logic [2:0] REG_X_MIN = 3'd0;
	localparam logic [2:0] REG_Y_MIN = 3'd1;
	localparam logic [2:0] REG_X_MAX = 3'd2;
	localparam logic [2:0] REG_Y_MAX = 3'd3;
	localparam logic [2:0] REG_MODE  = 3'd4;

	// job numbering: corners against the segment, then endpoints against edges
	localparam logic [3:0] FIRST_JOB   = 4'd0;
	localparam logic [3:0] LAST_CORNER = 4'd3;
	localparam logic [3:0] FIRST_EDGE  = 4'd4;
	localparam logic [3:0] LAST_JOB    = 4'd11;

	// multiplier operand select
	localparam logic [2:0] MS_DXUX = 3'd0;
	localparam logic [2:0] MS_DYUY = 3'd1;
	localparam logic [2:0] MS_DXDX = 3'd2;
	localparam logic [2:0] MS_DYDY = 3'd3;
	localparam logic [2:0] MS_EXEX = 3'd4;
	localparam logic [2:0] MS_EYEY = 3'd5;

	// accumulator operations
	localparam logic [2:0] ACC_NONE    = 3'd0;
	localparam logic [2:0] ACC_DOT_LD  = 3'd1;
	localparam logic [2:0] ACC_DOT_ADD = 3'd2;
	localparam logic [2:0] ACC_LEN_LD  = 3'd3;
	localparam logic [2:0] ACC_LEN_ADD = 3'd4;
	localparam logic [2:0] ACC_SQ_LD   = 3'd5;
	localparam logic [2:0] ACC_SQ_ADD  = 3'd6;

	// nearest point picks
	localparam logic [1:0] PICK_NONE = 2'd0;
	localparam logic [1:0] PICK_A    = 2'd1;
	localparam logic [1:0] PICK_B    = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_CLEAR   = 2'd0;
	localparam logic [1:0] KIND_DEGEN   = 2'd1;
	localparam logic [1:0] KIND_INVALID = 2'd2;
	localparam logic [1:0] KIND_DIST    = 2'd3;

	typedef struct packed {
		logic                 operation;
		logic signed [DW-1:0] start_x;
		logic signed [DW-1:0] start_y;
		logic signed [DW-1:0] end_x;
		logic signed [DW-1:0] end_y;
		logic signed [DW-1:0] margin;
	} item_t;

	typedef struct packed {
		logic                 is_valid;
		logic signed [DW-1:0] distance;
		logic                 degenerate;
	} res_t;

	typedef struct packed {
		logic signed [DW-1:0] x_min;
		logic signed [DW-1:0] y_min;
		logic signed [DW-1:0] x_max;
		logic signed [DW-1:0] y_max;
		logic                 obstacle;
	} cfg_t;

	typedef struct packed {
		logic       latch_in;
		logic       clr1;
		logic       clr2;
		logic       init;
		logic       region;
		logic       load_job;
		logic [3:0] job;
		logic [2:0] msel;
		logic [2:0] acc;
		logic [1:0] pick;
		logic       scale_start;
		logic       scale_y;
		logic       take_x;
		logic       take_y;
		logic       chk_box;
		logic       load_e;
		logic       sqrt_start;
		logic       take_root;
		logic       out_load;
		logic [1:0] kind;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic degen;
		logic obstacle;
		logic ok;
		logic dot_le0;
		logic dot_ge;
		logic scale_done;
		logic sqrt_done;
	} sts_t;

endpackage

// ===== hdl/rscc_if.sv =====
// valid/ready channel interfaces for query items and answer items
// depends on nothing
`timescale 1ns / 1ps

interface rscc_query_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic signed [31:0] end_x;
	logic signed [31:0] end_y;
	logic signed [31:0] margin;

	modport source (output valid, operation, start_x, start_y, end_x, end_y, margin,
		input ready);
	modport sink (input valid, operation, start_x, start_y, end_x, end_y, margin,
		output ready);
endinterface

interface rscc_answer_if;
	logic        valid;
	logic        ready;
	logic        is_valid;
	logic signed [31:0] distance;
	logic        degenerate;

	modport source (output valid, is_valid, distance, degenerate, input ready);
	modport sink (input valid, is_valid, distance, degenerate, output ready);
endinterface

// ===== hdl/rscc_scale.sv =====
// serial multiply then restoring divide: q = floor(m * dot / len2)
// depends on nothing; q must fit 32 bits (dot below len2)
`timescale 1ns / 1ps

module rscc_scale (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] m,
	input  logic [64:0] dot,
	input  logic [64:0] len2,
	output logic [31:0] q,
	output logic        done
);

	localparam logic [5:0] LAST_STEP = 6'd63;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [96:0] p_q;
	logic [64:0] dot_q;
	logic [64:0] len_q;
	logic [65:0] sum;
	logic [65:0] r2;
	logic [65:0] diff;
	logic        ge;

	always_comb begin
		sum  = {1'b0, p_q[96:32]} + (p_q[0] ? {1'b0, dot_q} : 66'd0);
		r2   = {p_q[96:32], p_q[31]};
		ge   = r2 >= {1'b0, len_q};
		diff = r2 - {1'b0, len_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == LAST_STEP)
					busy_q <= 1'b0;
			end
		end
	end

	// first 32 steps multiply lsb first, last 32 divide msb first
	always_ff @(posedge clk) begin
		if (start) begin
			p_q   <= {65'd0, m};
			dot_q <= dot;
			len_q <= len2;
		end else if (busy_q) begin
			if (!cnt_q[5])
				p_q <= {sum, p_q[31:1]};
			else
				p_q <= {(ge ? diff[64:0] : r2[64:0]), p_q[30:0], ge};
		end
	end

	assign q    = p_q[31:0];
	assign done = done_q;

endmodule

// ===== hdl/rscc_isqrt.sv =====
// digit by digit integer square root, two radicand bits a step
// depends on nothing
`timescale 1ns / 1ps

module rscc_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [65:0] n,
	output logic [32:0] root,
	output logic        done
);

	localparam logic [5:0] LAST_STEP = 6'd32;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [65:0] n_q;
	logic [34:0] rem_q;
	logic [32:0] root_q;
	logic [36:0] r4;
	logic [36:0] trial;
	logic [36:0] diff;
	logic        ge;

	always_comb begin
		r4    = {rem_q, n_q[65:64]};
		trial = {2'b00, root_q, 2'b01};
		ge    = r4 >= trial;
		diff  = r4 - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == LAST_STEP)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= n;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q    <= {n_q[63:0], 2'b00};
			rem_q  <= ge ? diff[34:0] : r4[34:0];
			root_q <= {root_q[31:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// ===== hdl/rscc_datapath.sv =====
// datapath: input and result registers, shared 33x33 multiplier, accumulators,
// nearest point, clearance and distance logic; uses rscc_pkg, rscc_scale, rscc_isqrt
`timescale 1ns / 1ps

module rscc_datapath #(
	parameter int unsigned CW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rscc_pkg::item_t item,
	input  rscc_pkg::cfg_t  cfg,
	input  rscc_pkg::cmd_t  cmd,
	output rscc_pkg::sts_t  sts,
	output rscc_pkg::res_t  res
);
	import rscc_pkg::*;

	localparam logic signed [34:0] CLR_HI  = 35'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic signed [34:0] CLR_LO  = -CLR_HI - 35'sd1;
	localparam logic [33:0]        DIST_HI = 34'((64'd1 << (CW - 1)) - 64'd1);

	function automatic logic signed [32:0] ext33(input logic signed [31:0] v);
		return {v[31], v};
	endfunction

	function automatic logic in_box(input cfg_t c, input logic signed [31:0] x,
		input logic signed [31:0] y);
		return (c.x_min <= x) && (x <= c.x_max) && (c.y_min <= y) && (y <= c.y_max);
	endfunction

	// corner order: top right, top left, bottom left, bottom right
	function automatic logic [63:0] corner(input cfg_t c, input logic [1:0] i);
		logic [63:0] v;
		case (i)
			2'd0:    v = {c.x_max, c.y_max};
			2'd1:    v = {c.x_min, c.y_max};
			2'd2:    v = {c.x_min, c.y_min};
			default: v = {c.x_max, c.y_min};
		endcase
		return v;
	endfunction

	logic                op_q;
	logic signed [31:0]  sx_q, sy_q, ex_q, ey_q, margin_q;
	logic signed [32:0]  mmax_q;
	logic signed [31:0]  clr_q;
	logic signed [31:0]  px_q, py_q, ax_q, ay_q, bx_q, by_q;
	logic signed [32:0]  dx_q, dy_q, ux_q, uy_q;
	logic signed [31:0]  cx_q, cy_q;
	logic signed [32:0]  erx_q, ery_q;
	logic signed [65:0]  mul_q;
	logic signed [66:0]  dot_q;
	logic [64:0]         len_q;
	logic [64:0]         sq_q;
	logic [33:0]         best_q;
	logic                ok_q;
	res_t                res_q;

	logic [63:0]         pv, av, bv;
	logic [2:0]          ek;
	logic signed [32:0]  ca, cb, cc, ce, m01, m23, mmax;
	logic signed [33:0]  r;
	logic signed [34:0]  t;
	logic signed [31:0]  clr;
	logic signed [32:0]  mul_a, mul_b;
	logic [32:0]         mag_sel;
	logic [31:0]         q;
	logic                scale_done;
	logic [32:0]         root;
	logic                sqrt_done;
	logic signed [32:0]  off;
	logic signed [32:0]  cn;

	// job operands
	always_comb begin
		ek = 3'(cmd.job - FIRST_EDGE);
		if (cmd.job <= LAST_CORNER) begin
			pv = corner(cfg, cmd.job[1:0]);
			av = {sx_q, sy_q};
			bv = {ex_q, ey_q};
		end else begin
			pv = ek[0] ? {ex_q, ey_q} : {sx_q, sy_q};
			av = corner(cfg, ek[2:1]);
			bv = corner(cfg, 2'(ek[2:1] + 2'd1));
		end
	end

	// clearance
	always_comb begin
		ca   = ext33(cfg.x_min) - ext33(sx_q);
		cb   = ext33(sx_q) - ext33(cfg.x_max);
		cc   = ext33(cfg.y_min) - ext33(sy_q);
		ce   = ext33(sy_q) - ext33(cfg.y_max);
		m01  = (ca > cb) ? ca : cb;
		m23  = (cc > ce) ? cc : ce;
		mmax = (m01 > m23) ? m01 : m23;
		r    = cfg.obstacle ? {mmax_q[32], mmax_q} : -{mmax_q[32], mmax_q};
		t    = {r[33], r} - {{3{margin_q[31]}}, margin_q};
		if (t > CLR_HI)
			clr = CLR_HI[31:0];
		else if (t < CLR_LO)
			clr = CLR_LO[31:0];
		else
			clr = t[31:0];
	end

	always_comb begin
		unique case (cmd.msel)
			MS_DXUX: begin mul_a = dx_q;  mul_b = ux_q;  end
			MS_DYUY: begin mul_a = dy_q;  mul_b = uy_q;  end
			MS_DXDX: begin mul_a = dx_q;  mul_b = dx_q;  end
			MS_DYDY: begin mul_a = dy_q;  mul_b = dy_q;  end
			MS_EXEX: begin mul_a = erx_q; mul_b = erx_q; end
			MS_EYEY: begin mul_a = ery_q; mul_b = ery_q; end
			default: begin mul_a = '0;    mul_b = '0;    end
		endcase
		mag_sel = cmd.scale_y ? (dy_q[32] ? -dy_q : dy_q) : (dx_q[32] ? -dx_q : dx_q);
		off     = (cmd.take_y ? dy_q[32] : dx_q[32]) ? -{1'b0, q} : {1'b0, q};
		cn      = (cmd.take_y ? ext33(ay_q) : ext33(ax_q)) + off;
	end

	rscc_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.scale_start),
		.m      (mag_sel[31:0]),
		.dot    (dot_q[64:0]),
		.len2   (len_q),
		.q      (q),
		.done   (scale_done)
	);

	rscc_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.n      ({1'b0, sq_q}),
		.root   (root),
		.done   (sqrt_done)
	);

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;

		if (cmd.latch_in) begin
			op_q     <= item.operation;
			sx_q     <= item.start_x;
			sy_q     <= item.start_y;
			ex_q     <= item.end_x;
			ey_q     <= item.end_y;
			margin_q <= item.margin;
		end
		if (cmd.clr1)
			mmax_q <= mmax;
		if (cmd.clr2)
			clr_q <= clr;

		if (cmd.init) begin
			best_q <= '1;
			ok_q   <= cmd.region ? (in_box(cfg, sx_q, sy_q) && in_box(cfg, ex_q, ey_q))
				: 1'b1;
		end else if (cmd.chk_box && in_box(cfg, cx_q, cy_q)) begin
			ok_q <= 1'b0;
		end

		if (cmd.load_job) begin
			px_q <= pv[63:32];
			py_q <= pv[31:0];
			ax_q <= av[63:32];
			ay_q <= av[31:0];
			bx_q <= bv[63:32];
			by_q <= bv[31:0];
			dx_q <= ext33(bv[63:32]) - ext33(av[63:32]);
			dy_q <= ext33(bv[31:0]) - ext33(av[31:0]);
			ux_q <= ext33(pv[63:32]) - ext33(av[63:32]);
			uy_q <= ext33(pv[31:0]) - ext33(av[31:0]);
		end

		case (cmd.acc)
			ACC_DOT_LD:  dot_q <= {mul_q[65], mul_q};
			ACC_DOT_ADD: dot_q <= dot_q + {mul_q[65], mul_q};
			ACC_LEN_LD:  len_q <= mul_q[64:0];
			ACC_LEN_ADD: len_q <= len_q + mul_q[64:0];
			ACC_SQ_LD:   sq_q  <= mul_q[64:0];
			ACC_SQ_ADD:  sq_q  <= sq_q + mul_q[64:0];
			default: ;
		endcase

		case (cmd.pick)
			PICK_A: begin cx_q <= ax_q; cy_q <= ay_q; end
			PICK_B: begin cx_q <= bx_q; cy_q <= by_q; end
			default: ;
		endcase
		if (cmd.take_x && scale_done)
			cx_q <= cn[31:0];
		if (cmd.take_y && scale_done)
			cy_q <= cn[31:0];

		if (cmd.load_e) begin
			erx_q <= ext33(px_q) - ext33(cx_q);
			ery_q <= ext33(py_q) - ext33(cy_q);
		end
		if (cmd.take_root && sqrt_done && ({1'b0, root} < best_q))
			best_q <= {1'b0, root};

		if (cmd.out_load) begin
			unique case (cmd.kind)
				KIND_CLEAR:   res_q <= '{is_valid: 1'b1, distance: clr_q, degenerate: 1'b0};
				KIND_DEGEN:   res_q <= '{is_valid: 1'b0, distance: '0, degenerate: 1'b1};
				KIND_INVALID: res_q <= '{is_valid: 1'b0, distance: '0, degenerate: 1'b0};
				KIND_DIST:    res_q <= '{is_valid: 1'b1,
					distance: (best_q > DIST_HI) ? DIST_HI[31:0] : best_q[31:0],
					degenerate: 1'b0};
				default:      res_q <= '{is_valid: 1'b0, distance: '0, degenerate: 1'b0};
			endcase
		end
	end

	always_comb begin
		sts.op         = op_q;
		sts.degen      = (sx_q == ex_q) && (sy_q == ey_q);
		sts.obstacle   = cfg.obstacle;
		sts.ok         = ok_q;
		sts.dot_le0    = dot_q[66] || (dot_q == '0);
		sts.dot_ge     = !dot_q[66] && (dot_q[65:0] >= {1'b0, len_q});
		sts.scale_done = scale_done;
		sts.sqrt_done  = sqrt_done;
	end

	assign res = res_q;

endmodule

// ===== hdl/rscc_ctrl.sv =====
// controller: sequences the clearance query, up to twelve distance jobs and the output handshake
// uses rscc_pkg; drives the datapath by cmd_t and reads sts_t
`timescale 1ns / 1ps

module rscc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output rscc_pkg::cmd_t cmd,
	input  rscc_pkg::sts_t sts
);
	import rscc_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_OP   = 5'd1;
	localparam logic [4:0] ST_CLR1 = 5'd2;
	localparam logic [4:0] ST_CLR2 = 5'd3;
	localparam logic [4:0] ST_SEG  = 5'd4;
	localparam logic [4:0] ST_RCHK = 5'd5;
	localparam logic [4:0] ST_DIFF = 5'd6;
	localparam logic [4:0] ST_M1   = 5'd7;
	localparam logic [4:0] ST_M2   = 5'd8;
	localparam logic [4:0] ST_M3   = 5'd9;
	localparam logic [4:0] ST_M4   = 5'd10;
	localparam logic [4:0] ST_M5   = 5'd11;
	localparam logic [4:0] ST_CLS  = 5'd12;
	localparam logic [4:0] ST_SCX  = 5'd13;
	localparam logic [4:0] ST_SCXW = 5'd14;
	localparam logic [4:0] ST_SCY  = 5'd15;
	localparam logic [4:0] ST_SCYW = 5'd16;
	localparam logic [4:0] ST_NEAR = 5'd17;
	localparam logic [4:0] ST_EDIF = 5'd18;
	localparam logic [4:0] ST_Q1   = 5'd19;
	localparam logic [4:0] ST_Q2   = 5'd20;
	localparam logic [4:0] ST_Q3   = 5'd21;
	localparam logic [4:0] ST_SQ   = 5'd22;
	localparam logic [4:0] ST_SQW  = 5'd23;
	localparam logic [4:0] ST_NEXT = 5'd24;
	localparam logic [4:0] ST_FIN  = 5'd25;

	logic [4:0] state_q, state_d;
	logic [3:0] job_q, job_d;
	logic [1:0] kind_q, kind_d;
	logic       out_valid_q;

	always_comb begin
		state_d  = state_q;
		job_d    = job_q;
		kind_d   = kind_q;
		cmd      = '0;
		cmd.msel = MS_DXUX;
		cmd.acc  = ACC_NONE;
		cmd.pick = PICK_NONE;
		cmd.job  = job_q;
		cmd.kind = kind_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_OP;
				end
			end
			ST_OP:   state_d = sts.op ? ST_CLR1 : ST_SEG;
			ST_CLR1: begin
				cmd.clr1 = 1'b1;
				state_d  = ST_CLR2;
			end
			ST_CLR2: begin
				cmd.clr2 = 1'b1;
				kind_d   = KIND_CLEAR;
				state_d  = ST_FIN;
			end
			ST_SEG: begin
				if (sts.degen) begin
					kind_d  = KIND_DEGEN;
					state_d = ST_FIN;
				end else begin
					cmd.init   = 1'b1;
					cmd.region = !sts.obstacle;
					job_d      = FIRST_JOB;
					state_d    = sts.obstacle ? ST_DIFF : ST_RCHK;
				end
			end
			ST_RCHK: begin
				if (sts.ok) begin
					job_d   = FIRST_EDGE;
					state_d = ST_DIFF;
				end else begin
					kind_d  = KIND_INVALID;
					state_d = ST_FIN;
				end
			end
			ST_DIFF: begin
				cmd.load_job = 1'b1;
				state_d      = ST_M1;
			end
			ST_M1: begin
				cmd.msel = MS_DXUX;
				state_d  = ST_M2;
			end
			ST_M2: begin
				cmd.msel = MS_DYUY;
				cmd.acc  = ACC_DOT_LD;
				state_d  = ST_M3;
			end
			ST_M3: begin
				cmd.msel = MS_DXDX;
				cmd.acc  = ACC_DOT_ADD;
				state_d  = ST_M4;
			end
			ST_M4: begin
				cmd.msel = MS_DYDY;
				cmd.acc  = ACC_LEN_LD;
				state_d  = ST_M5;
			end
			ST_M5: begin
				cmd.acc = ACC_LEN_ADD;
				state_d = ST_CLS;
			end
			ST_CLS: begin
				if (sts.dot_le0) begin
					cmd.pick = PICK_A;
					state_d  = ST_NEAR;
				end else if (sts.dot_ge) begin
					cmd.pick = PICK_B;
					state_d  = ST_NEAR;
				end else begin
					state_d = ST_SCX;
				end
			end
			ST_SCX: begin
				cmd.scale_start = 1'b1;
				state_d         = ST_SCXW;
			end
			ST_SCXW: begin
				cmd.take_x = 1'b1;
				if (sts.scale_done)
					state_d = ST_SCY;
			end
			ST_SCY: begin
				cmd.scale_start = 1'b1;
				cmd.scale_y     = 1'b1;
				state_d         = ST_SCYW;
			end
			ST_SCYW: begin
				cmd.take_y = 1'b1;
				if (sts.scale_done)
					state_d = ST_NEAR;
			end
			ST_NEAR: begin
				cmd.chk_box = (job_q <= LAST_CORNER);
				state_d     = ST_EDIF;
			end
			ST_EDIF: begin
				cmd.load_e = 1'b1;
				state_d    = ST_Q1;
			end
			ST_Q1: begin
				cmd.msel = MS_EXEX;
				state_d  = ST_Q2;
			end
			ST_Q2: begin
				cmd.msel = MS_EYEY;
				cmd.acc  = ACC_SQ_LD;
				state_d  = ST_Q3;
			end
			ST_Q3: begin
				cmd.acc = ACC_SQ_ADD;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.sqrt_start = 1'b1;
				state_d        = ST_SQW;
			end
			ST_SQW: begin
				cmd.take_root = 1'b1;
				if (sts.sqrt_done)
					state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if ((job_q == LAST_CORNER) && !sts.ok) begin
					kind_d  = KIND_INVALID;
					state_d = ST_FIN;
				end else if (job_q == LAST_JOB) begin
					kind_d  = KIND_DIST;
					state_d = ST_FIN;
				end else begin
					job_d   = job_q + 4'd1;
					state_d = ST_DIFF;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= FIRST_JOB;
			kind_q      <= KIND_INVALID;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			kind_q  <= kind_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && (state_q == ST_IDLE) |=> state_q == ST_OP)
		else $error("accepted item did not start work");
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("answer appeared outside finish");
	a_job_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> job_q <= LAST_JOB)
		else $error("job index out of range");
	a_scale_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCXW || state_q == ST_SCYW) && sts.scale_done
		|=> state_q == ST_SCY || state_q == ST_NEAR)
		else $error("scale result not taken");
`endif

endmodule

// ===== hdl/rectangle_segment_clearance_check.sv =====
// top level: configuration registers, input sign extension, controller and datapath
// uses rscc_pkg, rscc_if, rscc_ctrl, rscc_datapath
//
//  channel  | kind        | transfer when            | payload
//  ---------+-------------+--------------------------+---------------------------------
//  query    | valid/ready | query.valid & ready      | operation, start/end x/y, margin
//  answer   | valid/ready | answer.valid & ready     | is_valid, distance, degenerate
//  apb      | psel/penable| psel & penable & pwrite  | box edges, obstacle_mode
//
// one item at a time. a segment check runs up to twelve point-to-segment jobs (four corners,
// then eight endpoint/edge pairs); a job whose nearest point is not an end runs the shared
// multiply-divide unit (64 steps per coordinate), and every job runs the root unit
// (33 steps).
// reset clears control state and loads the box registers; no clearing pass.
// a finished answer waits in the output register while the next query is taken;
// a new answer is held back only while the previous one is still not taken.
`timescale 1ns / 1ps

module rectangle_segment_clearance_check #(
	parameter int unsigned COORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	rscc_query_if.sink         query,
	rscc_answer_if.source      answer,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import rscc_pkg::*;

	// effective coordinate width, clamped to 2..32
	localparam int unsigned CW = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);
	localparam int unsigned SH = 32 - CW;
	// box maxima reset to 1.0
	localparam logic [63:0]        ONE_RAW = 64'd1 << FRAC_BITS;
	localparam logic [31:0]        ONE_LO  = ONE_RAW[31:0];
	localparam logic signed [31:0] BOX_ONE = $signed(ONE_LO << SH) >>> SH;

	// sign extend from the effective coordinate width
	function automatic logic signed [31:0] sext(input logic [31:0] v);
		return $signed(v << SH) >>> SH;
	endfunction

	cfg_t  cfg_q;
	item_t item;
	cmd_t  cmd;
	sts_t  sts;
	res_t  res;
	logic  wr_en;
	logic  in_ready;
	logic  out_valid;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_min    <= '0;
			cfg_q.y_min    <= '0;
			cfg_q.x_max    <= BOX_ONE;
			cfg_q.y_max    <= BOX_ONE;
			cfg_q.obstacle <= 1'b1;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_X_MIN: cfg_q.x_min    <= sext(pwdata);
				REG_Y_MIN: cfg_q.y_min    <= sext(pwdata);
				REG_X_MAX: cfg_q.x_max    <= sext(pwdata);
				REG_Y_MAX: cfg_q.y_max    <= sext(pwdata);
				REG_MODE:  cfg_q.obstacle <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[4:2])
			REG_X_MIN: prdata = cfg_q.x_min;
			REG_Y_MIN: prdata = cfg_q.y_min;
			REG_X_MAX: prdata = cfg_q.x_max;
			REG_Y_MAX: prdata = cfg_q.y_max;
			REG_MODE:  prdata = {31'd0, cfg_q.obstacle};
			default:   prdata = '0;
		endcase
	end

	// query payload, sign extended at the boundary
	always_comb begin
		item.operation = query.operation;
		item.start_x   = sext(query.start_x);
		item.start_y   = sext(query.start_y);
		item.end_x     = sext(query.end_x);
		item.end_y     = sext(query.end_y);
		item.margin    = sext(query.margin);
	end

	rscc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (query.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (answer.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rscc_datapath #(
		.CW (CW)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

	assign query.ready       = in_ready;
	assign answer.valid      = out_valid;
	assign answer.is_valid   = res.is_valid;
	assign answer.distance   = res.distance;
	assign answer.degenerate = res.degenerate;

endmodule

// ===== bench/tb_rectangle_segment_clearance_check.sv =====
// self-checking bench for the rectangle segment clearance checker
// depends on rscc_pkg, rscc_if and the rectangle_segment_clearance_check top level
`timescale 1ns / 1ps

module tb_rectangle_segment_clearance_check;
	import rscc_pkg::*;

	localparam longint ONE = 65536;
	localparam longint CYCLE_LIMIT = 12000000;
	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;

	typedef logic signed [127:0] wide_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	rscc_query_if qi();
	rscc_answer_if ai();

	rectangle_segment_clearance_check u_top (
		.clk(clk), .arst_n(arst_n), .query(qi), .answer(ai),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the box registers
	longint box_x0 = 0, box_y0 = 0, box_x1 = ONE, box_y1 = ONE;
	bit obstacle = 1'b1;

	item_t query_backlog[$];
	res_t answer_expect_q[$];
	bit failed = 0;
	bit quiet = 0;
	int answers_seen = 0;
	longint cycles = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// nearest point to p on segment a-b, offsets truncated toward a
	function automatic longint scaled_offset(longint d, wide_t dot, wide_t len2);
		wide_t m, q;
		m = d < 0 ? -wide_t'(d) : wide_t'(d);
		q = (m * dot) / len2;
		return d < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic void nearest_point(input longint px, py, ax, ay, bx, by,
			output longint cx, cy);
		longint dx, dy;
		wide_t dot, len2;
		dx = bx - ax;
		dy = by - ay;
		dot = wide_t'(dx) * wide_t'(px - ax) + wide_t'(dy) * wide_t'(py - ay);
		len2 = wide_t'(dx) * wide_t'(dx) + wide_t'(dy) * wide_t'(dy);
		if (dot <= 0) begin
			cx = ax; cy = ay;
		end else if (dot >= len2) begin
			cx = bx; cy = by;
		end else begin
			cx = ax + scaled_offset(dx, dot, len2);
			cy = ay + scaled_offset(dy, dot, len2);
		end
	endfunction

	function automatic logic [63:0] floor_root(logic [127:0] n);
		logic [63:0] r;
		logic [127:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = {64'd0, r | (64'd1 << b)};
			if (c * c <= n) r = c[63:0];
		end
		return r;
	endfunction

	function automatic logic [63:0] point_seg_dist(longint px, py, ax, ay, bx, by);
		longint cx, cy, ex, ey;
		nearest_point(px, py, ax, ay, bx, by, cx, cy);
		ex = px - cx;
		ey = py - cy;
		return floor_root(wide_t'(ex) * wide_t'(ex) + wide_t'(ey) * wide_t'(ey));
	endfunction

	function automatic bit inside_box(longint x, y);
		return box_x0 <= x && x <= box_x1 && box_y0 <= y && y <= box_y1;
	endfunction

	function automatic logic [31:0] clip32(longint v);
		if (v > SMAX) return 32'h7fffffff;
		if (v < SMIN) return 32'h80000000;
		return v[31:0];
	endfunction

	// expected answer for one query under the current box
	function automatic res_t clearance_predict(item_t it);
		res_t r;
		longint sx, sy, ex, ey, a, b, c, e, m, cx, cy;
		longint vx[4], vy[4];
		logic [63:0] best, d;
		bit ok;
		sx = longint'(it.start_x); sy = longint'(it.start_y);
		ex = longint'(it.end_x); ey = longint'(it.end_y);
		r = '0;
		if (it.operation) begin
			a = box_x0 - sx; b = sx - box_x1; c = box_y0 - sy; e = sy - box_y1;
			if (obstacle) begin
				m = a;
				if (b > m) m = b;
				if (c > m) m = c;
				if (e > m) m = e;
			end else begin
				m = -a;
				if (-b < m) m = -b;
				if (-c < m) m = -c;
				if (-e < m) m = -e;
			end
			r.is_valid = 1;
			r.distance = clip32(m - longint'(it.margin));
			return r;
		end
		if (sx == ex && sy == ey) begin
			r.degenerate = 1;
			return r;
		end
		vx[0] = box_x1; vy[0] = box_y1;
		vx[1] = box_x0; vy[1] = box_y1;
		vx[2] = box_x0; vy[2] = box_y0;
		vx[3] = box_x1; vy[3] = box_y0;
		best = '1;
		if (obstacle) begin
			ok = 1;
			for (int i = 0; i < 4; i++) begin
				nearest_point(vx[i], vy[i], sx, sy, ex, ey, cx, cy);
				if (inside_box(cx, cy)) ok = 0;
				d = point_seg_dist(vx[i], vy[i], sx, sy, ex, ey);
				if (d < best) best = d;
			end
		end else begin
			ok = inside_box(sx, sy) && inside_box(ex, ey);
		end
		if (!ok) return r;
		for (int i = 0; i < 4; i++) begin
			d = point_seg_dist(sx, sy, vx[i], vy[i], vx[(i + 1) % 4], vy[(i + 1) % 4]);
			if (d < best) best = d;
			d = point_seg_dist(ex, ey, vx[i], vy[i], vx[(i + 1) % 4], vy[(i + 1) % 4]);
			if (d < best) best = d;
		end
		r.is_valid = 1;
		r.distance = best > 64'd2147483647 ? 32'h7fffffff : best[31:0];
		return r;
	endfunction

	// coordinate near, on or far from the box along one axis
	function automatic logic [31:0] pick_coord(longint lo, longint hi);
		longint v;
		case ($urandom_range(0, 9))
			0: v = longint'($urandom);
			1: v = $urandom_range(0, 1) ? SMAX : SMIN;
			2, 3, 4: v = ($urandom_range(0, 1) ? lo : hi)
				+ longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
			5: v = ($urandom_range(0, 1) ? lo : hi) + longint'($urandom_range(0, 2)) - 1;
			default: begin
				if (hi >= lo) v = lo + ((hi - lo) * longint'($urandom_range(0, 1000))) / 1000;
				else v = lo + longint'($urandom_range(0, 4 * ONE)) - 2 * ONE;
			end
		endcase
		return clip32(v);
	endfunction

	function automatic item_t random_query();
		item_t it;
		it.operation = ($urandom_range(0, 2) == 0);
		it.start_x = pick_coord(box_x0, box_x1);
		it.start_y = pick_coord(box_y0, box_y1);
		it.end_x = pick_coord(box_x0, box_x1);
		it.end_y = pick_coord(box_y0, box_y1);
		if ($urandom_range(0, 19) == 0) begin
			it.end_x = it.start_x;
			it.end_y = it.start_y;
		end
		it.margin = $urandom_range(0, 3) == 0 ? $urandom
			: 32'(longint'($urandom_range(0, 4 * ONE)) - 2 * ONE);
		return it;
	endfunction

	function automatic item_t make_query(logic op, longint sx, sy, ex, ey, mg);
		item_t it;
		it.operation = op;
		it.start_x = sx[31:0]; it.start_y = sy[31:0];
		it.end_x = ex[31:0]; it.end_y = ey[31:0];
		it.margin = mg[31:0];
		return it;
	endfunction

	// two-phase register write; shadow follows at the write edge
	task automatic reg_write(logic [2:0] idx, longint v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= v[31:0];
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_X_MIN: box_x0 = longint'(signed'(v[31:0]));
			REG_Y_MIN: box_y0 = longint'(signed'(v[31:0]));
			REG_X_MAX: box_x1 = longint'(signed'(v[31:0]));
			REG_Y_MAX: box_y1 = longint'(signed'(v[31:0]));
			REG_MODE:  obstacle = v[0];
			default: ;
		endcase
	endtask

	task automatic set_box(longint x0, y0, x1, y1, bit obs);
		reg_write(REG_X_MIN, x0);
		reg_write(REG_Y_MIN, y0);
		reg_write(REG_X_MAX, x1);
		reg_write(REG_Y_MAX, y1);
		reg_write(REG_MODE, longint'(obs));
	endtask

	// every query has exactly one answer, so an empty store means idle;
	// sampled at the falling edge so the driver's updates have settled
	task automatic drain();
		@(negedge clk);
		while (query_backlog.size() != 0 || qi.valid || answer_expect_q.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		repeat (n) query_backlog.push_back(random_query());
		drain();
	endtask

	// query driver: pops the backlog, predicts at each transfer
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (qi.valid && qi.ready)
				answer_expect_q.push_back(clearance_predict(item_t'({qi.operation,
					qi.start_x, qi.start_y, qi.end_x, qi.end_y, qi.margin})));
			if (!qi.valid || qi.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					qi.valid <= 0;
				end else if (!quiet && $urandom_range(0, 15) == 0) begin
					gap_left <= $urandom_range(0, 14);
					qi.valid <= 0;
				end else if (query_backlog.size() > 0) begin
					automatic item_t it = query_backlog.pop_front();
					qi.operation <= it.operation;
					qi.start_x <= it.start_x;
					qi.start_y <= it.start_y;
					qi.end_x <= it.end_x;
					qi.end_y <= it.end_y;
					qi.margin <= it.margin;
					qi.valid <= 1;
				end else begin
					qi.valid <= 0;
				end
			end
		end
	end

	// answer monitor: random stalls, one long hold-off to back the block up
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (ai.valid && ai.ready) begin
				answers_seen <= answers_seen + 1;
				if (answer_expect_q.size() == 0) begin
					$display("%0t: answer with none expected: valid %b dist %0d degen %b",
						$time, ai.is_valid, ai.distance, ai.degenerate);
					failed = 1;
				end else begin
					automatic res_t x = answer_expect_q.pop_front();
					if (ai.is_valid !== x.is_valid)
						$display("%0t: is_valid expected %b actual %b", $time,
							x.is_valid, ai.is_valid);
					if (ai.distance !== x.distance)
						$display("%0t: distance expected %0d actual %0d", $time,
							x.distance, ai.distance);
					if (ai.degenerate !== x.degenerate)
						$display("%0t: degenerate expected %b actual %b", $time,
							x.degenerate, ai.degenerate);
					if (ai.is_valid !== x.is_valid || ai.distance !== x.distance
						|| ai.degenerate !== x.degenerate)
						failed = 1;
				end
			end
			if (answers_seen == 300 && !hold_done) begin
				hold_left <= 3000;
				hold_done <= 1;
				ai.ready <= 0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				ai.ready <= 0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				ai.ready <= 0;
			end else if (!quiet && $urandom_range(0, 19) == 0) begin
				stall_left <= $urandom_range(0, 14);
				ai.ready <= 0;
			end else begin
				ai.ready <= 1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		qi.valid = 0; qi.operation = 0; qi.start_x = 0; qi.start_y = 0;
		qi.end_x = 0; qi.end_y = 0; qi.margin = 0;
		ai.ready = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// directed, reset box (unit square obstacle)
		query_backlog.push_back(make_query(1, ONE / 2, ONE / 2, 0, 0, 0));
		query_backlog.push_back(make_query(1, SMAX, SMIN, 0, 0, SMIN));
		query_backlog.push_back(make_query(1, SMIN, SMAX, 0, 0, SMAX));
		query_backlog.push_back(make_query(1, 3 * ONE, -ONE, 7, 9, -ONE));
		query_backlog.push_back(make_query(0, 5, 5, 5, 5, 0));
		query_backlog.push_back(make_query(0, -ONE, -ONE, 2 * ONE, 2 * ONE, 0));
		query_backlog.push_back(make_query(0, 2 * ONE, 0, 2 * ONE, ONE, 0));
		query_backlog.push_back(make_query(0, -ONE, 2 * ONE, 3 * ONE, 2 * ONE + 3, 0));
		query_backlog.push_back(make_query(0, SMIN, SMIN, SMAX, SMAX, 0));
		query_backlog.push_back(make_query(0, SMIN, SMAX, SMAX, SMAX, 0));
		query_backlog.push_back(make_query(0, SMAX, SMIN, SMAX, SMAX, 0));
		query_backlog.push_back(make_query(0, ONE, ONE, 2 * ONE, 3 * ONE, 0));
		query_backlog.push_back(make_query(0, 3 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 0));
		drain();

		// region mode, the unit square as allowed area
		set_box(0, 0, ONE, ONE, 0);
		query_backlog.push_back(make_query(0, ONE / 4, ONE / 4, ONE / 2, 3 * ONE / 4, 0));
		query_backlog.push_back(make_query(0, 0, 0, ONE, ONE, 0));
		query_backlog.push_back(make_query(0, ONE / 4, ONE / 4, 2 * ONE, ONE / 2, 0));
		query_backlog.push_back(make_query(1, ONE / 4, ONE / 2, 0, 0, 0));
		query_backlog.push_back(make_query(1, 5 * ONE, ONE / 2, 0, 0, SMAX));
		drain();

		set_box(-2 * ONE, -ONE, 3 * ONE, 2 * ONE, 1);
		random_phase(250);
		reg_write(REG_MODE, 0);
		random_phase(250);
		// box covering the whole coordinate range
		set_box(SMIN, SMIN, SMAX, SMAX, 1);
		random_phase(150);
		reg_write(REG_MODE, 0);
		random_phase(150);
		// zero-width box, then an unordered one
		set_box(ONE, -ONE, ONE, ONE, 1);
		random_phase(150);
		set_box(3 * ONE, 2 * ONE, -ONE, -ONE, 1);
		random_phase(150);
		reg_write(REG_MODE, 0);
		random_phase(100);
		for (int k = 0; k < 3; k++) begin
			automatic longint a = longint'(signed'($urandom));
			automatic longint b = a + longint'($urandom_range(1, 64 * ONE));
			automatic longint c = longint'(signed'($urandom)) / 4;
			if (b > SMAX) b = SMAX;
			set_box(a, c, b, c + longint'($urandom_range(1, 64 * ONE)), k[0]);
			if (k == 2) quiet = 1;
			random_phase(150);
		end

		repeat (50) @(posedge clk);
		if (!failed) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
